// ----- hdl/ws_pkg.sv -----
// ----------------------------------------------------------------------------
// ws_pkg
// Shared types and constants for the LED strip frame serializer.
// ----------------------------------------------------------------------------
package ws_pkg;

  localparam int LED_COUNT = 64;
  localparam int LED_AW    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int POS_W     = $clog2(LED_COUNT + 1);
  localparam int PIX_W     = 24;
  localparam int BIT_W     = 5;
  localparam logic [BIT_W-1:0] TOP_BIT = 5'd23;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [15:0] HIGH_DUTY_RST   = 16'd79;
  localparam logic [15:0] LOW_DUTY_RST    = 16'd39;
  localparam logic [7:0]  RESET_SLOTS_RST = 8'd50;

  typedef enum logic [1:0] {
    OP_SET_PIXEL = 2'd0,
    OP_CLEAR     = 2'd1,
    OP_SHOW      = 2'd2,
    OP_TICK      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_HIGH_DUTY   = 2'd0,
    CFG_LOW_DUTY    = 2'd1,
    CFG_RESET_SLOTS = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_DRAIN,
    ST_EMIT
  } state_t;

endpackage

// ----- hdl/ws2812_frame_serializer_unit.sv -----
// A sending tick enters ST_EMIT, which loads the output register and raises out_tvalid.
// Throughput: set_pixel, clear and idle ticks every cycle while in ST_IDLE; a sending
//   tick holds input off in ST_EMIT until its slot, read into frame_q_r, is emitted.
// show holds in_tready low in ST_COPY and ST_DRAIN while the pixel memory is copied.
// Reset (rst_n low, synchronous) clears the pixel valid bits, the frame counters,
//   the output valid flag and restores the default duty/slot registers.
// ----------------------------------------------------------------------------
// ws2812_frame_serializer_unit
// Pixel store plus frame snapshot, serialized into one PWM duty per bit slot.
// ----------------------------------------------------------------------------
module ws2812_frame_serializer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: pixel_index[9:0], red[17:10], green[25:18], blue[33:26], zero pad
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ws_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: operation[1:0]
  input  logic [1:0]                        in_tuser,
  // out_tdata: duty[15:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ws_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ws_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ws_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ws_pkg::*;

  logic [PIX_W-1:0] pix_mem   [LED_COUNT];
  logic [PIX_W-1:0] frame_mem [LED_COUNT];

  state_t state_r, state_nxt;

  logic [LED_COUNT-1:0] pix_vld_r;
  logic [15:0]          high_duty_r, low_duty_r;
  logic [7:0]           reset_slots_r;

  logic                 sending_r;
  logic [POS_W-1:0]     pix_pos_r;
  logic [BIT_W-1:0]     bit_pos_r;
  logic [7:0]           rst_pos_r;

  logic [LED_AW-1:0]    cp_cnt_r;
  logic                 cp_wr_en_r;
  logic [LED_AW-1:0]    cp_wr_addr_r;
  logic [PIX_W-1:0]     pix_q_r;
  logic                 pix_q_vld_r;
  logic [PIX_W-1:0]     frame_q_r;

  logic                 out_valid_r;
  logic [15:0]          out_duty_r;
  logic                 out_last_r;

  logic                 in_acc;
  op_t                  op;
  logic [9:0]           idx;
  logic [PIX_W-1:0]     wr_word;
  logic                 pix_rd_en;
  logic                 emit_go;
  logic                 in_pixels;
  logic                 cur_bit;
  logic                 emit_last;
  logic [15:0]          emit_duty;

  assign op      = op_t'(in_tuser);
  assign idx     = in_tdata[9:0];
  assign wr_word = {in_tdata[25:18], in_tdata[17:10], in_tdata[33:26]};
  assign in_acc  = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && op == OP_SHOW) begin
          state_nxt = ST_COPY;
        end else if (in_acc && op == OP_TICK && sending_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_COPY: begin
        if (cp_cnt_r == LED_AW'(LED_COUNT - 1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_IDLE;
      ST_EMIT: begin
        if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_tready = 1'b0;
    pix_rd_en = 1'b0;
    emit_go   = 1'b0;
    case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_COPY:  pix_rd_en = 1'b1;
      ST_DRAIN: ;
      ST_EMIT:  emit_go   = !out_valid_r || out_tready;
      default:  ;
    endcase
  end

  // slot value
  assign in_pixels = pix_pos_r < POS_W'(LED_COUNT);
  assign cur_bit   = frame_q_r[bit_pos_r];
  always_comb begin
    if (in_pixels) begin
      emit_duty = cur_bit ? high_duty_r : low_duty_r;
      emit_last = (bit_pos_r == '0) && (pix_pos_r == POS_W'(LED_COUNT - 1))
                  && (reset_slots_r == '0);
    end else begin
      emit_duty = '0;
      emit_last = ({1'b0, rst_pos_r} + 9'd1) >= {1'b0, reset_slots_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_duty_r   <= HIGH_DUTY_RST;
      low_duty_r    <= LOW_DUTY_RST;
      reset_slots_r <= RESET_SLOTS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HIGH_DUTY:   high_duty_r   <= cfg_data;
        CFG_LOW_DUTY:    low_duty_r    <= cfg_data;
        CFG_RESET_SLOTS: reset_slots_r <= cfg_data[7:0];
        default:         ;
      endcase
    end
  end

  // pixel memory; a clear drops every valid bit, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (in_acc && op == OP_SET_PIXEL && idx < 10'(LED_COUNT)) begin
      pix_mem[idx[LED_AW-1:0]] <= wr_word;
    end
    if (pix_rd_en) begin
      pix_q_r     <= pix_mem[cp_cnt_r];
      pix_q_vld_r <= pix_vld_r[cp_cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_vld_r <= '0;
    end else if (in_acc && op == OP_CLEAR) begin
      pix_vld_r <= '0;
    end else if (in_acc && op == OP_SET_PIXEL && idx < 10'(LED_COUNT)) begin
      pix_vld_r[idx[LED_AW-1:0]] <= 1'b1;
    end
  end

  // snapshot copy: read at cp_cnt_r, write in the following cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_cnt_r   <= '0;
      cp_wr_en_r <= 1'b0;
    end else begin
      cp_wr_en_r <= pix_rd_en;
      if (pix_rd_en) begin
        cp_wr_addr_r <= cp_cnt_r;
        cp_cnt_r     <= (state_nxt == ST_COPY) ? cp_cnt_r + 1'b1 : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cp_wr_en_r) begin
      frame_mem[cp_wr_addr_r] <= pix_q_vld_r ? pix_q_r : '0;
    end
    if (in_acc && op == OP_TICK && sending_r && in_pixels) begin
      frame_q_r <= frame_mem[pix_pos_r[LED_AW-1:0]];
    end
  end

  // frame position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sending_r <= 1'b0;
      pix_pos_r <= '0;
      bit_pos_r <= TOP_BIT;
      rst_pos_r <= '0;
    end else if (in_acc && op == OP_SHOW) begin
      sending_r <= 1'b1;
      pix_pos_r <= '0;
      bit_pos_r <= TOP_BIT;
      rst_pos_r <= '0;
    end else if (emit_go) begin
      if (emit_last) sending_r <= 1'b0;
      if (in_pixels) begin
        if (bit_pos_r == '0) begin
          bit_pos_r <= TOP_BIT;
          pix_pos_r <= pix_pos_r + 1'b1;
        end else begin
          bit_pos_r <= bit_pos_r - 1'b1;
        end
      end else begin
        rst_pos_r <= rst_pos_r + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_duty_r <= emit_duty;
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_duty_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- hdl/ws_checker.sv -----
// ----------------------------------------------------------------------------
// ws_checker
// Port-level checks for the frame serializer, bound to the top level.
// ----------------------------------------------------------------------------
module ws_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [1:0]                     in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [ws_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                           out_tlast
);
  import ws_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // a show transaction starts the snapshot copy, input stalls
  a_show_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_SHOW |=> !in_tready ##1 !in_tready)
    else $error("input accepted during snapshot copy");

  // a new result only comes out of the emit cycle, when input is held off
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !$past(out_tvalid)) |-> !$past(in_tready))
    else $error("result appeared without an emit cycle");

endmodule

bind ws2812_frame_serializer_unit ws_checker u_ws_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
